FILE: rtl/csd_pkg.sv
// Shared constants for the cumulative spectrum distance block.
`timescale 1ns / 1ps
package csd_pkg;

    localparam logic [1:0] OP_LOAD_WIDTH  = 2'd0;
    localparam logic [1:0] OP_LOAD_SAMPLE = 2'd1;
    localparam logic [1:0] OP_PIXEL       = 2'd2;

    localparam logic REG_BANDS   = 1'b0;
    localparam logic REG_SAMPLES = 1'b1;

    localparam int CFG_W    = 6;
    localparam int WIDTH_W  = 16;
    localparam int PIX_W    = 16;
    localparam int SMPV_W   = 32;
    localparam int AREA_W   = 40;
    localparam int CUM_W    = 29;
    localparam int ROOT_W   = 35;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int REM_W    = ROOT_W + 2;
    localparam int SQ_W     = 2 * SMPV_W;

    localparam logic [ROOT_W-1:0] ROOT_MAX = {ROOT_W{1'b1}};

endpackage

FILE: rtl/csd_sqrt.sv
// Bit-serial floor square root, one result bit per cycle, saturating at 2^35-1.
`timescale 1ns / 1ps
module csd_sqrt
    import csd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic              sat,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;

    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial     = {{(REM_W+2-ROOT_W-2){1'b0}}, root_reg, 2'b01};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (go)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            cnt_next  = 6'(ROOT_W - 1);
            if (sat)
            begin
                root_next = ROOT_MAX;
                done_next = 1'b1;
            end
            else
            begin
                root_next = '0;
                run_next  = 1'b1;
            end
        end
        else if (run_reg)
        begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(rem_sh);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: rtl/cumulative_spectrum_distance_top.sv
// Top level of the cumulative spectrum distance engine.
//
// Input channel: an operation is taken at a clock edge with start high and
// busy low. Width loads and sample loads are written in that edge and leave
// busy low. A pixel for a band in use keeps busy high while its product
// with the band width is added into the running area and its integer part is
// stored for that band.
// On the last band in use the block then computes one distance per sample in
// use. For each sample, each band in use passes through the sample memory
// read, difference, 32x32 square and accumulate states, then a bit-serial
// square root of 35 steps runs. Each distance shows on
// sample_index_res, distance and last for one cycle with valid high; last
// marks the final sample. The receiver cannot stall; results are always
// delivered. Configuration is written through cfg_write / cfg_index /
// cfg_data, by the user only while busy is low; the block doesn't enforce it.
// Reset clears the control state, sets bands_in_use to 32 and samples_in_use
// to 16 and clears the running area; width and sample tables stay undefined
// until loaded.
`timescale 1ns / 1ps
module cumulative_spectrum_distance_top
    import csd_pkg::*;
#(
    parameter int NUM_BANDS   = 32,
    parameter int NUM_SAMPLES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            operation,
    input  logic [4:0]            band_index,
    input  logic [3:0]            sample_index,
    input  logic [31:0]           value,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output logic                  valid,
    output logic [3:0]            sample_index_res,
    output logic [ROOT_W-1:0]     distance,
    output logic                  last
);

    localparam int BAND_AW = $clog2(NUM_BANDS);
    localparam int SMP_AW  = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
    localparam int MEM_D   = NUM_SAMPLES * NUM_BANDS;
    localparam int MEM_AW  = $clog2(MEM_D);
    localparam int ACC_W   = (SQ_W + BAND_AW > RAD_W + 1) ? SQ_W + BAND_AW : RAD_W + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_AREA = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_DIF  = 4'd4;
    localparam logic [3:0] S_SQ   = 4'd5;
    localparam logic [3:0] S_ACC  = 4'd6;
    localparam logic [3:0] S_GO   = 4'd7;
    localparam logic [3:0] S_WAIT = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic [CFG_W-1:0]    bands_reg;
    logic [4:0]          samples_reg;
    logic [CFG_W-1:0]    nb;
    logic [4:0]          ns;

    logic [WIDTH_W-1:0]  width_tab [NUM_BANDS];
    logic [CUM_W-1:0]    cum_store [NUM_BANDS];
    logic [SMPV_W-1:0]   sample_mem [MEM_D];

    logic [BAND_AW-1:0]  band_reg, band_next;
    logic [PIX_W-1:0]    pix_reg, pix_next;
    logic                first_reg, first_next;
    logic                lastb_reg, lastb_next;
    logic [31:0]         prod_reg, prod_next;
    logic [AREA_W-1:0]   area_reg, area_next;
    logic [AREA_W:0]     area_sum;
    logic [AREA_W-9:0]   area_int;
    logic [CUM_W-1:0]    cum_new;

    logic [BAND_AW-1:0]  b_reg, b_next;
    logic [SMP_AW-1:0]   s_reg, s_next;
    logic [MEM_AW-1:0]   base_reg, base_next;
    logic [MEM_AW-1:0]   rd_addr;
    logic [SMPV_W-1:0]   rd_data_reg;
    logic [SMPV_W-1:0]   cum_ext;
    logic [SMPV_W-1:0]   d_reg, d_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;

    logic                accept;
    logic                band_ok;
    logic                sample_ok;
    logic                pix_ok;
    logic                sqrt_go;
    logic                sqrt_done;
    logic [ROOT_W-1:0]   sqrt_root;

    logic                valid_reg, valid_next;
    logic [3:0]          sres_reg, sres_next;
    logic [ROOT_W-1:0]   dist_reg, dist_next;
    logic                last_reg, last_next;

    // Clamp the registers to the sizes the tables really have.
    always_comb
    begin
        if (bands_reg == '0)
            nb = CFG_W'(1);
        else if (int'(bands_reg) > NUM_BANDS)
            nb = CFG_W'(NUM_BANDS);
        else
            nb = bands_reg;
        if (samples_reg == '0)
            ns = 5'd1;
        else if (int'(samples_reg) > NUM_SAMPLES)
            ns = 5'(NUM_SAMPLES);
        else
            ns = samples_reg;
    end

    assign accept    = start && (state_reg == S_IDLE);
    assign band_ok   = int'(band_index) < NUM_BANDS;
    assign sample_ok = int'(sample_index) < NUM_SAMPLES;
    assign pix_ok    = (operation == OP_PIXEL) && (CFG_W'(band_index) < nb);
    assign rd_addr   = base_reg + MEM_AW'(b_reg);
    assign cum_ext   = SMPV_W'(cum_store[b_reg]);
    assign sqrt_go   = (state_reg == S_GO);

    // Running area: restart on band zero, saturate at the top.
    always_comb
    begin
        if (first_reg)
            area_sum = (AREA_W + 1)'(prod_reg);
        else
            area_sum = {1'b0, area_reg} + (AREA_W + 1)'(prod_reg);
        area_next = area_sum[AREA_W] ? {AREA_W{1'b1}} : area_sum[AREA_W-1:0];
        area_int  = area_next[AREA_W-1:8];
        cum_new   = (area_int > (AREA_W - 8)'({CUM_W{1'b1}})) ? {CUM_W{1'b1}}
                                                              : CUM_W'(area_int);
    end

    always_comb
    begin
        state_next = state_reg;
        band_next  = band_reg;
        pix_next   = pix_reg;
        first_next = first_reg;
        lastb_next = lastb_reg;
        prod_next  = prod_reg;
        b_next     = b_reg;
        s_next     = s_reg;
        base_next  = base_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        acc_next   = acc_reg;
        valid_next = 1'b0;
        sres_next  = sres_reg;
        dist_next  = dist_reg;
        last_next  = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && pix_ok)
                begin
                    band_next  = BAND_AW'(band_index);
                    pix_next   = value[PIX_W-1:0];
                    first_next = (band_index == '0);
                    lastb_next = (CFG_W'(band_index) == nb - CFG_W'(1));
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = 32'(width_tab[band_reg]) * 32'(pix_reg);
                state_next = S_AREA;
            end
            S_AREA:
            begin
                b_next    = '0;
                s_next    = '0;
                base_next = '0;
                acc_next  = '0;
                state_next = lastb_reg ? S_RD : S_IDLE;
            end
            S_RD:
            begin
                state_next = S_DIF;
            end
            S_DIF:
            begin
                d_next = (rd_data_reg > cum_ext) ? rd_data_reg - cum_ext
                                                 : cum_ext - rd_data_reg;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                sq_next    = SQ_W'(d_reg) * SQ_W'(d_reg);
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next = acc_reg + ACC_W'(sq_reg);
                if (int'(b_reg) == int'(nb) - 1)
                begin
                    state_next = S_GO;
                end
                else
                begin
                    b_next     = b_reg + BAND_AW'(1);
                    state_next = S_RD;
                end
            end
            S_GO:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (sqrt_done)
                begin
                    valid_next = 1'b1;
                    sres_next  = 4'(s_reg);
                    dist_next  = sqrt_root;
                    last_next  = (int'(s_reg) == int'(ns) - 1);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (last_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    s_next     = s_reg + SMP_AW'(1);
                    base_next  = base_reg + MEM_AW'(NUM_BANDS);
                    b_next     = '0;
                    acc_next   = '0;
                    state_next = S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bands_reg   <= CFG_W'(32);
            samples_reg <= 5'd16;
            area_reg    <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (state_reg == S_AREA)
                area_reg <= area_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_BANDS:   bands_reg   <= cfg_data;
                    REG_SAMPLES: samples_reg <= cfg_data[4:0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        band_reg  <= band_next;
        pix_reg   <= pix_next;
        first_reg <= first_next;
        lastb_reg <= lastb_next;
        prod_reg  <= prod_next;
        b_reg     <= b_next;
        s_reg     <= s_next;
        base_reg  <= base_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        acc_reg   <= acc_next;
        sres_reg  <= sres_next;
        dist_reg  <= dist_next;
        last_reg  <= last_next;
    end

    // Tables: width and cumulative store in flops, samples in a memory.
    always_ff @(posedge clk)
    begin
        if (accept && (operation == OP_LOAD_WIDTH) && band_ok)
            width_tab[BAND_AW'(band_index)] <= value[WIDTH_W-1:0];
        if (state_reg == S_AREA)
            cum_store[band_reg] <= cum_new;
    end

    always_ff @(posedge clk)
    begin
        if (accept && (operation == OP_LOAD_SAMPLE) && band_ok && sample_ok)
            sample_mem[MEM_AW'(int'(sample_index) * NUM_BANDS + int'(band_index))]
                <= value;
        rd_data_reg <= sample_mem[rd_addr];
    end

    csd_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (sqrt_go),
        .sat      (|acc_reg[ACC_W-1:RAD_W]),
        .radicand (acc_reg[RAD_W-1:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign busy             = (state_reg != S_IDLE);
    assign valid            = valid_reg;
    assign sample_index_res = sres_reg;
    assign distance         = dist_reg;
    assign last             = last_reg;

endmodule

FILE: rtl/csd_checker.sv
// Port-level checker for the cumulative spectrum distance engine, with its bind.
`timescale 1ns / 1ps
module csd_props
    import csd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] operation,
    input logic       valid,
    input logic       last
);

    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy)
        else $error("result strobe outside a busy period");

    a_valid_single: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !valid)
        else $error("result strobe held for two cycles");

    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !last) |=> busy)
        else $error("block went idle before the final sample");

    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation != OP_PIXEL)) |=> !busy)
        else $error("load transaction made the block busy");

endmodule

bind cumulative_spectrum_distance_top csd_props u_csd_props
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .valid     (valid),
    .last      (last)
);

FILE: tb/csd_checker.sv
// Predictor and result checker for the cumulative spectrum distance block.
`timescale 1ns / 1ps
module csd_checker
    import csd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [1:0]        operation,
    input  logic [4:0]        band_index,
    input  logic [3:0]        sample_index,
    input  logic [31:0]       value,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              valid,
    input  logic [3:0]        sample_index_res,
    input  logic [ROOT_W-1:0] distance,
    input  logic              last,
    output int                errors,
    output int                pending
);

    localparam int BANDS   = 32;
    localparam int SAMPLES = 16;
    localparam logic [AREA_W-1:0] AREA_SAT = {AREA_W{1'b1}};
    localparam logic [CUM_W-1:0]  CUM_SAT  = {CUM_W{1'b1}};

    typedef struct packed {
        logic [3:0]        smp;
        logic [ROOT_W-1:0] root;
        logic              fin;
    } distance_t;

    logic [WIDTH_W-1:0] band_width [BANDS];
    logic [SMPV_W-1:0]  ref_cum [SAMPLES*BANDS];
    logic [CUM_W-1:0]   pixel_cum [BANDS];
    logic [AREA_W-1:0]  area;
    logic [5:0]         bands_reg;
    logic [4:0]         samples_reg;
    distance_t          expected_q [$];

    function automatic logic [ROOT_W-1:0] floor_root(input logic [RAD_W-1:0] n);
        logic [ROOT_W-1:0] r;
        logic [ROOT_W-1:0] c;
        r = '0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            c = r | (ROOT_W'(1) << b);
            if (RAD_W'(c) * RAD_W'(c) <= n)
                r = c;
        end
        return r;
    endfunction

    function automatic int clamp(input int v, input int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    // Apply one accepted transaction to the predicted state; queue distances.
    task automatic absorb(input logic [1:0] op, input logic [4:0] band,
                          input logic [3:0] smp, input logic [31:0] val);
        int nb;
        int ns;
        logic [AREA_W:0]    sum;
        logic [31:0]        ip;
        logic [RAD_W-1:0]   acc;
        logic [SMPV_W-1:0]  a;
        logic [SMPV_W-1:0]  d;
        distance_t          e;
        nb = clamp(int'(bands_reg), BANDS);
        ns = clamp(int'(samples_reg), SAMPLES);
        if (op == OP_LOAD_WIDTH)
            band_width[band] = val[15:0];
        else if (op == OP_LOAD_SAMPLE)
            ref_cum[int'(smp) * BANDS + int'(band)] = val;
        else if (op == OP_PIXEL && int'(band) < nb) begin
            sum = (AREA_W + 1)'(band_width[band]) * (AREA_W + 1)'(val[15:0]);
            if (band != 0)
                sum = sum + {1'b0, area};
            area = (sum > {1'b0, AREA_SAT}) ? AREA_SAT : sum[AREA_W-1:0];
            ip = area[AREA_W-1:8];
            pixel_cum[band] = (ip > 32'(CUM_SAT)) ? CUM_SAT : ip[CUM_W-1:0];
            if (int'(band) == nb - 1) begin
                for (int s = 0; s < ns; s++) begin
                    acc = '0;
                    for (int b = 0; b < nb; b++) begin
                        a = ref_cum[s * BANDS + b];
                        d = (a > 32'(pixel_cum[b])) ? a - 32'(pixel_cum[b])
                                                    : 32'(pixel_cum[b]) - a;
                        acc = acc + RAD_W'(64'(d) * 64'(d));
                    end
                    e.smp  = s[3:0];
                    e.root = floor_root(acc);
                    e.fin  = (s == ns - 1);
                    expected_q.push_back(e);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        distance_t e;
        if (!rst_n) begin
            area        = '0;
            bands_reg   = 6'd32;
            samples_reg = 5'd16;
            errors      = 0;
            pending     = 0;
            expected_q.delete();
        end
        else begin
            if (valid) begin
                if (expected_q.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: unexpected distance smp=%0d dist=%0d last=%0b",
                                 $time, sample_index_res, distance, last);
                    errors = errors + 1;
                end
                else begin
                    e = expected_q.pop_front();
                    if (e.smp !== sample_index_res || e.root !== distance
                        || e.fin !== last) begin
                        if (errors < 10)
                            $display("%0t: mismatch exp %0d/%0d/%0b got %0d/%0d/%0b",
                                     $time, e.smp, e.root, e.fin,
                                     sample_index_res, distance, last);
                        errors = errors + 1;
                    end
                end
            end
            if (cfg_write) begin
                if (cfg_index == REG_BANDS)
                    bands_reg = cfg_data;
                else
                    samples_reg = cfg_data[4:0];
            end
            if (start && !busy)
                absorb(operation, band_index, sample_index, value);
            pending = expected_q.size();
        end
    end

endmodule

FILE: tb/tb.sv
// Stimulus, clock, reset and verdict for the cumulative spectrum distance block.
`timescale 1ns / 1ps
module tb
    import csd_pkg::*;
();

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        operation = OP_LOAD_WIDTH;
    logic [4:0]        band_index = '0;
    logic [3:0]        sample_index = '0;
    logic [31:0]       value = '0;
    logic              cfg_write = 1'b0;
    logic              cfg_index = REG_BANDS;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              valid;
    logic [3:0]        sample_index_res;
    logic [ROOT_W-1:0] distance;
    logic              last;
    int                errors;
    int                pending;
    int                cycles = 0;
    int                gap_pct = 0;
    int                bands_now = 32;

    cumulative_spectrum_distance_top dut (.*);

    csd_checker checker_i (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** cumulative_spectrum_distance_top: FAILED **");
            $finish;
        end
    end

    // Offer one transaction; hold it until accepted, with random gaps first.
    task automatic issue(input logic [1:0] op, input logic [4:0] band,
                         input logic [3:0] smp, input logic [31:0] val);
        if ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        start        <= 1'b1;
        operation    <= op;
        band_index   <= band;
        sample_index <= smp;
        value        <= val;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_reg(input logic idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic pixel();
        for (int b = 0; b < bands_now; b++)
        begin
            issue(OP_PIXEL, b[4:0], 4'($urandom), $urandom);
            // drop in a stray transaction now and then
            if ($urandom_range(9) == 0)
                issue(2'($urandom), 5'($urandom), 4'($urandom), $urandom);
        end
    endtask

    initial
    begin
        logic [5:0] band_cfg [6];
        logic [5:0] smp_cfg  [6];
        int sent;
        // wide configurations use two samples; many samples go with few bands
        band_cfg = '{6'd5, 6'd1, 6'd63, 6'd0, 6'd2, 6'd32};
        smp_cfg  = '{6'd2, 6'd16, 6'd2, 6'd0, 6'd63, 6'd2};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every table entry that the configurations below can read
        for (int b = 0; b < 32; b++)
            issue(OP_LOAD_WIDTH, b[4:0], 4'($urandom),
                  (b == 0) ? 32'hFFFF_FFFF : ((b == 1) ? 32'h0 : $urandom));
        for (int s = 0; s < 16; s++)
            for (int b = 0; b < ((s < 2) ? 32 : 2); b++)
                issue(OP_LOAD_SAMPLE, b[4:0], s[3:0],
                      (s == 0) ? 32'hFFFF_FFFF : ((s == 1) ? 32'h0 : $urandom));
        drain();
        set_reg(REG_SAMPLES, 6'd2);

        // directed: unknown op, then a full pixel with extreme values
        issue(OP_UNUSED, 5'd31, 4'd15, 32'hFFFF_FFFF);
        for (int b = 0; b < 32; b++)
            issue(OP_PIXEL, b[4:0], 4'd0,
                  (b < 2) ? 32'h0000_FFFF : ((b == 2) ? 32'h0 : $urandom));
        drain();

        for (int k = 0; k < 6; k++)
        begin
            gap_pct = (k < 2) ? 37 : ((k < 4) ? 85 : 0);
            drain();
            set_reg(REG_BANDS, band_cfg[k]);
            set_reg(REG_SAMPLES, smp_cfg[k]);
            bands_now = (band_cfg[k] == 0) ? 1 : ((band_cfg[k] > 32) ? 32 : band_cfg[k]);
            sent = 0;
            while (sent < 10)
            begin
                if ($urandom_range(99) < 80)
                begin
                    pixel();
                    sent += bands_now;
                end
                else
                begin
                    issue(2'($urandom), 5'($urandom), 4'($urandom), $urandom);
                    sent++;
                end
            end
        end

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("** cumulative_spectrum_distance_top: PASSED **");
        else
            $display("** cumulative_spectrum_distance_top: FAILED **");
        $finish;
    end

endmodule
